// ===== sv/csac_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, sizes and codes for the coherent set-associative cache.
// No dependencies.
package csac_pkg;
    localparam int SETS       = 64;
    localparam int WAYS       = 8;
    localparam int LINE_BYTES = 64;
    localparam int ADDR_BITS  = 48;
    localparam int AGE_BITS   = 16;

    localparam int OFF_BITS = $clog2(LINE_BYTES);
    localparam int SET_BITS = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int TAG_BITS = ADDR_BITS - OFF_BITS - $clog2(SETS);
    localparam int WAY_BITS = 3;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_STORE = 2'd1;
    localparam logic [1:0] OP_DOWN  = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    localparam logic [1:0] ST_INVALID   = 2'd0;
    localparam logic [1:0] ST_SHARED    = 2'd1;
    localparam logic [1:0] ST_EXCLUSIVE = 2'd2;
    localparam logic [1:0] ST_MODIFIED  = 2'd3;

    localparam logic [2:0] OC_HIT         = 3'd0;
    localparam logic [2:0] OC_UPGRADE     = 3'd1;
    localparam logic [2:0] OC_MISS        = 3'd2;
    localparam logic [2:0] OC_DOWN_DONE   = 3'd3;
    localparam logic [2:0] OC_DOWN_ABSENT = 3'd4;

    typedef struct packed {
        logic [TAG_BITS-1:0] tag;
        logic [1:0]          state;
        logic                safe;
        logic [AGE_BITS-1:0] age;
    } t_line;

    typedef t_line [WAYS-1:0] t_row;

    typedef struct packed {
        logic [1:0]          op;
        logic [TAG_BITS-1:0] tag;
        logic [SET_BITS-1:0] set;
        logic [1:0]          reply_state;
        logic                reply_safe;
        logic                down_state;
        logic                down_safe;
    } t_req;

    typedef struct packed {
        logic [2:0]           outcome;
        logic [WAY_BITS-1:0]  hit_way;
        logic                 safe_hit;
        logic                 evict_valid;
        logic [ADDR_BITS-1:0] evict_address;
        logic                 flush_flag;
    } t_res;
endpackage

// ===== sv/csac_ram.sv =====
`timescale 1ns / 1ps
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module csac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/csac_update.sv =====
`timescale 1ns / 1ps
// Per-item lookup, victim choice and new set row for the cache.
// Depends on csac_pkg.
module csac_update import csac_pkg::*; (
    input  t_req i_req,
    input  t_row i_row,
    output t_row o_row,
    output t_res o_res
);
    localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

    always_comb begin
        logic                found;
        logic [WAY_BITS-1:0] fway;
        logic                inv_found;
        logic [WAY_BITS-1:0] vway;
        logic [AGE_BITS-1:0] best;
        logic [WAY_BITS-1:0] way;
        logic                touch;

        found     = 1'b0;
        fway      = '0;
        inv_found = 1'b0;
        vway      = '0;
        best      = '0;
        touch     = 1'b0;
        o_row     = i_row;
        o_res     = '0;

        // first matching valid way
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (i_row[w].state != ST_INVALID && i_row[w].tag == i_req.tag) begin
                found = 1'b1;
                fway  = WAY_BITS'(w);
            end
        end
        // victim: first invalid way, else oldest, lowest on ties
        for (int w = 0; w < WAYS; w++) begin
            if (!inv_found) begin
                if (i_row[w].state == ST_INVALID) begin
                    inv_found = 1'b1;
                    vway      = WAY_BITS'(w);
                end else if (i_row[w].age > best) begin
                    best = i_row[w].age;
                    vway = WAY_BITS'(w);
                end
            end
        end

        way = fway;
        if (i_req.op == OP_DOWN) begin
            if (!found) begin
                o_res.outcome = OC_DOWN_ABSENT;
                way = '0;
            end else begin
                o_res.flush_flag    = i_row[fway].safe & ~i_req.down_safe;
                o_row[fway].state   = {1'b0, i_req.down_state};
                o_row[fway].safe    = i_req.down_safe;
                o_res.outcome       = OC_DOWN_DONE;
            end
        end else if (found && !(i_req.op == OP_STORE && i_row[fway].state < ST_EXCLUSIVE)) begin
            if (i_req.op == OP_STORE) begin
                o_row[fway].state = ST_MODIFIED;
            end
            o_res.safe_hit = i_row[fway].safe;
            o_res.outcome  = OC_HIT;
            touch = 1'b1;
        end else if (found) begin
            o_row[fway].state = i_req.reply_state;
            o_row[fway].safe  = i_req.reply_safe;
            o_res.outcome     = OC_UPGRADE;
            touch = 1'b1;
        end else begin
            way = vway;
            if (i_row[vway].state != ST_INVALID) begin
                o_res.evict_valid   = 1'b1;
                o_res.evict_address = {i_row[vway].tag, i_req.set, {OFF_BITS{1'b0}}};
            end
            o_row[vway].tag   = i_req.tag;
            o_row[vway].state = i_req.reply_state;
            o_row[vway].safe  = i_req.reply_safe;
            o_res.outcome     = OC_MISS;
            touch = 1'b1;
        end
        o_res.hit_way = way;

        if (touch) begin
            for (int w = 0; w < WAYS; w++) begin
                if (WAY_BITS'(w) == way) begin
                    o_row[w].age = '0;
                end else if (i_row[w].age != AGE_MAX) begin
                    o_row[w].age = i_row[w].age + 1'b1;
                end
            end
        end
    end
endmodule

// ===== sv/coherent_set_assoc_cache_lru.sv =====
`timescale 1ns / 1ps
// Coherent set-associative cache tag/state array with age-based LRU.
// Set RAM read, then update into the output register; one beat per cycle while
// the output is not stalled. The set row written by one beat is forwarded to a
// following beat of the same set, so back-to-back hits on a set are fine.
// Reset: synchronous, active low; clears pipeline valids and per-set row valids
// (an unwritten set reads as all invalid, age zero). No clearing pass needed.
module coherent_set_assoc_cache_lru import csac_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: address[47:0], reply_state[49:48], reply_safe[50], down_state[51],
    //        down_safe[52], zero pad [55:53]
    input  logic [55:0] s_tdata,
    // tuser: operation[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: hit_way[2:0], safe_hit[3], evict_valid[4], evict_address[52:5],
    //        flush_flag[53], zero pad [55:54]
    output logic [55:0] m_tdata,
    // tuser: outcome[2:0]
    output logic [2:0]  m_tuser
);
    localparam int ROW_W = $bits(t_row);

    logic                r_req_valid;
    t_req                r_req;
    logic [SETS-1:0]     r_row_valid;
    logic                r_byp_valid;
    logic [SET_BITS-1:0] r_byp_set;
    t_row                r_byp_row;
    logic                r_out_valid;
    t_res                r_out;

    logic                adv;
    logic                acc;
    t_req                n_req;
    logic [ROW_W-1:0]    ram_rdata;
    t_row                cur_row;
    t_row                new_row;
    t_res                res;
    logic                wr;

    // whole pipe moves when the output register is free or being drained
    assign adv      = !r_out_valid || m_tready;
    assign s_tready = adv;
    assign acc      = s_tvalid && adv;

    always_comb begin
        n_req.op          = s_tuser;
        n_req.set         = SET_BITS'(s_tdata[ADDR_BITS-1:0] >> OFF_BITS);
        n_req.tag         = TAG_BITS'(s_tdata[ADDR_BITS-1:0] >> (ADDR_BITS - TAG_BITS));
        n_req.reply_state = s_tdata[49:48];
        n_req.reply_safe  = s_tdata[50];
        n_req.down_state  = s_tdata[51];
        n_req.down_safe   = s_tdata[52];
    end

    csac_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_rows (
        .i_clk  (i_clk),
        .i_we   (wr),
        .i_waddr(r_req.set),
        .i_wdata(new_row),
        .i_re   (adv),
        .i_raddr(n_req.set),
        .o_rdata(ram_rdata)
    );

    // forward last written row, else RAM data gated by the row valid
    always_comb begin
        if (r_byp_valid && r_byp_set == r_req.set) begin
            cur_row = r_byp_row;
        end else if (r_row_valid[r_req.set]) begin
            cur_row = t_row'(ram_rdata);
        end else begin
            cur_row = '0;
        end
    end

    csac_update u_update (
        .i_req(r_req),
        .i_row(cur_row),
        .o_row(new_row),
        .o_res(res)
    );

    // the no-op code (OP_NONE) changes nothing and gives no result
    assign wr = adv && r_req_valid && r_req.op != OP_NONE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
            r_row_valid <= '0;
            r_byp_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_req_valid <= acc;
            r_byp_valid <= wr;
            r_out_valid <= wr;
            if (wr) begin
                r_row_valid[r_req.set] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_req     <= n_req;
            r_byp_set <= r_req.set;
            r_byp_row <= new_row;
            r_out     <= res;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tuser  = r_out.outcome;
    assign m_tdata  = {2'b00, r_out.flush_flag, r_out.evict_address, r_out.evict_valid,
                       r_out.safe_hit, r_out.hit_way};
endmodule

// ===== test/coherent_set_assoc_cache_lru_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for coherent_set_assoc_cache_lru: directed and random
// loads, stores and downgrades checked against a behavioral tag/state array.
// Depends on csac_pkg and the RTL top level.
module coherent_set_assoc_cache_lru_tb;
    import csac_pkg::*;

    localparam int  AGE_MAX     = (1 << AGE_BITS) - 1;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  N_RANDOM    = 1830;

    typedef struct packed {
        logic [1:0]  op;
        logic [55:0] data;
    } t_beat;

    typedef struct packed {
        logic [2:0]  outcome;
        logic [55:0] data;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [2:0]  m_tuser;

    coherent_set_assoc_cache_lru u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Behavioral copy of the tag/state array
    logic [TAG_BITS-1:0] mdl_tag   [SETS][WAYS];
    logic [1:0]          mdl_state [SETS][WAYS];
    logic                mdl_safe  [SETS][WAYS];
    int unsigned         mdl_age   [SETS][WAYS];

    t_beat   pending_beats[$];
    t_result expected_results[$];
    int      errors = 0;
    int      cycle = 0;
    bit      stim_done = 0;
    bit      drain_hold = 0;   // sender waits for all results
    int      long_stall = 0;   // receiver hold-off countdown
    bit      stall_armed = 0;

    function automatic void age_set(int s, int used);
        for (int w = 0; w < WAYS; w++)
            if (mdl_age[s][w] < AGE_MAX) mdl_age[s][w]++;
        mdl_age[s][used] = 0;
    endfunction

    // Predicts the result of one accepted beat and updates the array
    function automatic void predict_access(t_beat b);
        logic [47:0]         addr;
        logic [1:0]          rst;
        logic                rsf, dst, dsf;
        int                  s, found, way;
        logic [TAG_BITS-1:0] tg;
        t_result             r;
        int unsigned         best;
        logic [2:0]          oc;
        logic                sh, ev, fl;
        logic [47:0]         ea;
        addr = b.data[47:0];
        rst  = b.data[49:48];
        rsf  = b.data[50];
        dst  = b.data[51];
        dsf  = b.data[52];
        s    = addr[OFF_BITS +: SET_BITS];
        tg   = addr[47 -: TAG_BITS];
        sh = 0; ev = 0; fl = 0; ea = '0; way = 0;
        if (b.op == OP_NONE) return;
        found = -1;
        for (int w = 0; w < WAYS; w++)
            if (found < 0 && mdl_state[s][w] != ST_INVALID && mdl_tag[s][w] == tg)
                found = w;
        if (b.op == OP_DOWN) begin
            if (found < 0) begin
                oc = OC_DOWN_ABSENT;
            end else begin
                way = found;
                fl = mdl_safe[s][way] && !dsf;
                mdl_state[s][way] = {1'b0, dst};
                mdl_safe[s][way]  = dsf;
                oc = OC_DOWN_DONE;
            end
        end else if (found >= 0 &&
                     !(b.op == OP_STORE && mdl_state[s][found] < ST_EXCLUSIVE)) begin
            way = found;
            if (b.op == OP_STORE) mdl_state[s][way] = ST_MODIFIED;
            sh = mdl_safe[s][way];
            oc = OC_HIT;
            age_set(s, way);
        end else if (found >= 0) begin
            way = found;
            mdl_state[s][way] = rst;
            mdl_safe[s][way]  = rsf;
            oc = OC_UPGRADE;
            age_set(s, way);
        end else begin
            best = 0;
            for (int w = 0; w < WAYS; w++) begin
                if (mdl_state[s][w] == ST_INVALID) begin
                    way = w;
                    break;
                end
                if (mdl_age[s][w] > best) begin
                    best = mdl_age[s][w];
                    way = w;
                end
            end
            if (mdl_state[s][way] != ST_INVALID) begin
                ev = 1;
                ea = {mdl_tag[s][way], SET_BITS'(s), {OFF_BITS{1'b0}}};
            end
            mdl_tag[s][way]   = tg;
            mdl_state[s][way] = rst;
            mdl_safe[s][way]  = rsf;
            oc = OC_MISS;
            age_set(s, way);
        end
        r.outcome = oc;
        r.data = {2'b00, fl, ea, ev, sh, 3'(way)};
        expected_results.push_back(r);
    endfunction

    function automatic t_beat make_beat(logic [1:0] op, logic [47:0] addr,
                                        logic [1:0] rs, logic rf, logic ds, logic df);
        t_beat b;
        b.op = op;
        b.data = {3'b000, df, ds, rf, rs, addr};
        return b;
    endfunction

    // Address from a small tag pool so sets fill, hit and evict
    function automatic logic [47:0] pick_addr();
        logic [47:0] a;
        a = 48'({$urandom, $urandom});
        if ($urandom_range(0, 9) != 0) begin
            a[47:OFF_BITS + SET_BITS] = (TAG_BITS)'($urandom_range(0, 11));
            a[OFF_BITS +: SET_BITS]   = (SET_BITS)'($urandom_range(0, 3));
        end
        return a;
    endfunction

    initial begin
        logic [47:0] a;
        logic [1:0]  op;
        for (int s = 0; s < SETS; s++)
            for (int w = 0; w < WAYS; w++) begin
                mdl_tag[s][w] = '0; mdl_state[s][w] = ST_INVALID;
                mdl_safe[s][w] = 0; mdl_age[s][w] = 0;
            end
        // directed: absent downgrade, fills of all states into one set, hits,
        // upgrades, downgrade with lost safety, address extremes, no-op
        pending_beats.push_back(make_beat(OP_DOWN, 48'h0, 2'd0, 0, 1, 1));
        pending_beats.push_back(make_beat(OP_LOAD, 48'h0, ST_SHARED, 1, 0, 0));
        pending_beats.push_back(make_beat(OP_LOAD, 48'h0, ST_SHARED, 0, 0, 0));
        pending_beats.push_back(make_beat(OP_STORE, 48'h0, ST_EXCLUSIVE, 0, 0, 0));
        pending_beats.push_back(make_beat(OP_STORE, 48'h0, ST_SHARED, 1, 0, 0));
        pending_beats.push_back(make_beat(OP_DOWN, 48'h0, 2'd0, 0, 1, 0));
        pending_beats.push_back(make_beat(OP_NONE, 48'h0, 2'd3, 1, 1, 1));
        pending_beats.push_back(make_beat(OP_LOAD, 48'hFFFF_FFFF_FFFF, ST_MODIFIED, 1, 1, 1));
        pending_beats.push_back(make_beat(OP_STORE, 48'hFFFF_FFFF_FFFF, 2'd0, 0, 0, 0));
        for (int i = 1; i <= 9; i++)
            pending_beats.push_back(make_beat(OP_LOAD, 48'(i) << 12,
                                              2'(i), i[0], 0, 0));
        pending_beats.push_back(make_beat(OP_LOAD, 48'h0, ST_INVALID, 0, 0, 0));
        pending_beats.push_back(make_beat(OP_DOWN, 48'h3000, 2'd0, 0, 0, 0));
        pending_beats.push_back(make_beat(OP_STORE, 48'h5000, ST_MODIFIED, 1, 0, 0));
        for (int i = 0; i < N_RANDOM; i++) begin
            a = pick_addr();
            case ($urandom_range(0, 19))
                0:       op = OP_NONE;
                1, 2, 3: op = OP_DOWN;
                4, 5, 6, 7, 8, 9, 10: op = OP_STORE;
                default: op = OP_LOAD;
            endcase
            pending_beats.push_back(make_beat(op, a, 2'($urandom), 1'($urandom),
                                              1'($urandom), 1'($urandom)));
        end
        stim_done = 1;
    end

    // Reset, then watchdog
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Driver: bursts and gaps; one drain pause mid-run
    int  gap_left = 0, burst_left = 0, sent = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_tvalid && s_tready) begin
                predict_access({s_tuser, s_tdata});
                sent <= sent + 1;
                if (sent == 900) drain_hold <= 1;
            end
            if (drain_hold && !(s_tvalid && s_tready) && !s_tvalid &&
                expected_results.size() == 0 && !m_tvalid)
                drain_hold <= 0;
            if (!(s_tvalid && !s_tready)) begin
                if (drain_hold || (s_tvalid && s_tready && sent == 900)) begin
                    s_tvalid <= 1'b0;
                end else if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_beats.size() > 0) begin
                    t_beat b;
                    b = pending_beats.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= b.data;
                    s_tuser  <= b.op;
                    if (burst_left == 0) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare and drive ready with its own stall pattern
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result outcome %0d data %h",
                             $time, m_tuser, m_tdata);
                    errors = errors + 1;
                end else begin
                    e = expected_results.pop_front();
                    if (m_tuser !== e.outcome) begin
                        $display("%0t: outcome exp %0d got %0d", $time, e.outcome, m_tuser);
                        errors = errors + 1;
                    end
                    if (m_tdata[2:0] !== e.data[2:0]) begin
                        $display("%0t: hit_way exp %0d got %0d", $time,
                                 e.data[2:0], m_tdata[2:0]);
                        errors = errors + 1;
                    end
                    if (m_tdata[3] !== e.data[3]) begin
                        $display("%0t: safe_hit exp %b got %b", $time, e.data[3], m_tdata[3]);
                        errors = errors + 1;
                    end
                    if (m_tdata[4] !== e.data[4]) begin
                        $display("%0t: evict_valid exp %b got %b", $time,
                                 e.data[4], m_tdata[4]);
                        errors = errors + 1;
                    end
                    if (m_tdata[52:5] !== e.data[52:5]) begin
                        $display("%0t: evict_address exp %h got %h", $time,
                                 e.data[52:5], m_tdata[52:5]);
                        errors = errors + 1;
                    end
                    if (m_tdata[53] !== e.data[53]) begin
                        $display("%0t: flush_flag exp %b got %b", $time,
                                 e.data[53], m_tdata[53]);
                        errors = errors + 1;
                    end
                end
            end
            // one long hold-off early in the run, so the pipe backs up
            if (!stall_armed && cycle > 400) begin
                stall_armed <= 1;
                long_stall  <= 60;
                m_tready    <= 1'b0;
            end else if (long_stall > 0) begin
                long_stall <= long_stall - 1;
                m_tready   <= 1'b0;
            end else if ((cycle / 150) % 2 == 0) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    // End of run
    initial begin
        wait (stim_done);
        wait (pending_beats.size() == 0 && !s_tvalid && expected_results.size() == 0);
        repeat (20) @(posedge i_clk);
        if (errors == 0 && expected_results.size() == 0 && !m_tvalid)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
